// ----- sv/tsd_pkg.sv -----
// Shared types, token and error codes, and keyword tables for the token scanner.
`timescale 1ns / 1ps

package tsd_pkg;

    // Default configuration of the scanner.
    localparam int KEY_CHARS_DEF   = 8;
    localparam int LENGTH_BITS_DEF = 16;

    // Queue depths.
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // Output field limits.
    localparam int               TOKEN_LEN_W = 16;
    localparam logic [30:0]      NUM_MAX     = 31'h7FFF_FFFF;

    // Token kinds in their fixed order.
    typedef enum logic [5:0] {
        TK_ID      = 6'd0,
        TK_NUM     = 6'd1,
        TK_LPAREN  = 6'd2,
        TK_RPAREN  = 6'd3,
        TK_LBRACE  = 6'd4,
        TK_RBRACE  = 6'd5,
        TK_BECOMES = 6'd6,
        TK_EQ      = 6'd7,
        TK_NE      = 6'd8,
        TK_LT      = 6'd9,
        TK_GT      = 6'd10,
        TK_LE      = 6'd11,
        TK_GE      = 6'd12,
        TK_PLUS    = 6'd13,
        TK_MINUS   = 6'd14,
        TK_STAR    = 6'd15,
        TK_SLASH   = 6'd16,
        TK_PCT     = 6'd17,
        TK_COMMA   = 6'd18,
        TK_SEMI    = 6'd19,
        TK_LBRACK  = 6'd20,
        TK_RBRACK  = 6'd21,
        TK_AMP     = 6'd22,
        TK_WAIN    = 6'd23,
        TK_INT     = 6'd24,
        TK_IF      = 6'd25,
        TK_ELSE    = 6'd26,
        TK_WHILE   = 6'd27,
        TK_PRINTLN = 6'd28,
        TK_RETURN  = 6'd29,
        TK_NULL    = 6'd30,
        TK_NEW     = 6'd31,
        TK_DELETE  = 6'd32
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_CHAR   = 2'd1,
        ERR_NUM_RANGE  = 2'd2,
        ERR_UNFINISHED = 2'd3
    } err_code_t;

    // Character classes that the front end attaches to every byte.
    typedef enum logic [3:0] {
        CC_ALPHA,
        CC_DIGIT,
        CC_BLANK,
        CC_NEWLINE,
        CC_EXCL,
        CC_EQ,
        CC_LT,
        CC_GT,
        CC_SLASH,
        CC_PUNCT,
        CC_BAD
    } char_cls_t;

    // Keywords, left aligned in seven bytes, in token kind order from TK_WAIN.
    localparam int KW_COUNT   = 10;
    localparam int KW_MAX_LEN = 7;
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"wain", 24'h0},
        {"int", 32'h0},
        {"if", 40'h0},
        {"else", 24'h0},
        {"while", 16'h0},
        "println",
        {"return", 8'h0},
        {"NULL", 24'h0},
        {"new", 32'h0},
        {"delete", 8'h0}
    };
    localparam int KW_LEN [KW_COUNT] = '{4, 3, 2, 4, 5, 7, 6, 4, 3, 6};

    // One input item.
    typedef struct packed {
        logic       action;
        logic [7:0] char_byte;
    } scan_in_t;

    // One item after classification, as it waits in the command queue.
    typedef struct packed {
        logic       action;
        logic [7:0] char_byte;
        char_cls_t  cls;
        tok_kind_t  start_kind;
    } scan_cmd_t;

    // One result item.
    typedef struct packed {
        tok_kind_t   token_kind;
        err_code_t   error_code;
        logic [31:0] token_start;
        logic [15:0] token_length;
        logic [30:0] number_value;
        logic        last_of_run;
    } token_t;

endpackage

// ----- sv/token_scanner_dfa.sv -----
// Top level of the maximal-munch token scanner: front end, engine and result queue.
//
//  Channel   Handshake          Payload    Direction
//  -------   ----------------   --------   ---------
//  input     push / full        cmd        into the block, one byte or end marker
//  result    pop / empty        token      out of the block, one token or error
//
// The block takes one input transfer per cycle while full is low. A classified
// byte waits in a four-entry command queue until the engine takes it; the engine
// writes its results into a four-entry result queue, from which the result ports
// read. An item that closes a token and starts another yields two results, which
// leave the result port one at a time; the engine holds its item while fewer than
// two result slots are free, and full rises once the command queue fills behind
// it. Reset clears both queues and returns the recognizer to its start state
// with the stream offset at zero.
`timescale 1ns / 1ps

module token_scanner_dfa
    import tsd_pkg::*;
#(
    parameter int KEY_CHARS   = KEY_CHARS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  scan_in_t cmd,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output token_t   token
);

    // Link between the front end and the engine.
    logic      cmd_avail;
    logic      cmd_take;
    scan_cmd_t cmd_head;

    // Link between the engine and the result queue.
    logic      res_room2;
    logic      res_wr0;
    logic      res_wr1;
    token_t    res_data0;
    token_t    res_data1;

    // The front end classifies each byte on its way into the command queue.
    tsd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .cmd   (cmd),
        .full  (full),
        .take  (cmd_take),
        .avail (cmd_avail),
        .head  (cmd_head)
    );

    // The engine runs the recognizer and builds zero, one or two results per item.
    tsd_engine #(
        .KEY_CHARS   (KEY_CHARS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (cmd_avail),
        .head  (cmd_head),
        .take  (cmd_take),
        .room2 (res_room2),
        .wr0   (res_wr0),
        .res0  (res_data0),
        .wr1   (res_wr1),
        .res1  (res_data1)
    );

    // The result queue decouples the engine from the consumer.
    tsd_result_fifo u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .wr0   (res_wr0),
        .data0 (res_data0),
        .wr1   (res_wr1),
        .data1 (res_data1),
        .room2 (res_room2),
        .empty (empty),
        .pop   (pop),
        .token (token)
    );

endmodule

// ----- sv/tsd_front.sv -----
// Front end: classifies each input byte and holds classified items in a short queue.
`timescale 1ns / 1ps

module tsd_front
    import tsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scan_in_t  cmd,
    output logic      full,
    input  logic      take,
    output logic      avail,
    output scan_cmd_t head
);

    localparam int AW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    scan_cmd_t      q [CMD_DEPTH];
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;
    scan_cmd_t      cls_item;

    // Byte classification, with the token kind that the byte starts.
    always_comb
    begin
        cls_item.action     = cmd.action;
        cls_item.char_byte  = cmd.char_byte;
        cls_item.cls        = CC_BAD;
        cls_item.start_kind = TK_ID;
        if (cmd.char_byte inside {["a":"z"], ["A":"Z"]})
        begin
            cls_item.cls = CC_ALPHA;
        end
        else if (cmd.char_byte inside {["0":"9"]})
        begin
            cls_item.cls        = CC_DIGIT;
            cls_item.start_kind = TK_NUM;
        end
        else
        begin
            case (cmd.char_byte)
                CH_SPACE, CH_TAB: cls_item.cls = CC_BLANK;
                CH_NEWLINE:       cls_item.cls = CC_NEWLINE;
                "!":              cls_item.cls = CC_EXCL;
                "=":
                begin
                    cls_item.cls        = CC_EQ;
                    cls_item.start_kind = TK_BECOMES;
                end
                "<":
                begin
                    cls_item.cls        = CC_LT;
                    cls_item.start_kind = TK_LT;
                end
                ">":
                begin
                    cls_item.cls        = CC_GT;
                    cls_item.start_kind = TK_GT;
                end
                "/":
                begin
                    cls_item.cls        = CC_SLASH;
                    cls_item.start_kind = TK_SLASH;
                end
                "(": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_LPAREN; end
                ")": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_RPAREN; end
                "{": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_LBRACE; end
                "}": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_RBRACE; end
                "+": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_PLUS; end
                "-": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_MINUS; end
                "*": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_STAR; end
                "%": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_PCT; end
                ",": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_COMMA; end
                ";": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_SEMI; end
                "[": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_LBRACK; end
                "]": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_RBRACK; end
                "&": begin cls_item.cls = CC_PUNCT; cls_item.start_kind = TK_AMP; end
                default: cls_item.cls = CC_BAD;
            endcase
        end
    end

    assign full    = (count_reg == CW'(CMD_DEPTH));
    assign avail   = (count_reg != '0);
    assign head    = q[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = take && avail;

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == AW'(CMD_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == AW'(CMD_DEPTH - 1)) ? '0 : rp_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q[wp_reg] <= cls_item;
        end
    end

endmodule

// ----- sv/tsd_result_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module tsd_result_fifo
    import tsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr0,
    input  token_t data0,
    input  logic   wr1,
    input  token_t data1,
    output logic   room2,
    output logic   empty,
    input  logic   pop,
    output token_t token
);

    localparam int AW = $clog2(RES_DEPTH);
    localparam int CW = $clog2(RES_DEPTH + 1);

    token_t         q [RES_DEPTH];
    logic [AW-1:0]  wp_reg, wp_next, wp_plus1;
    logic [AW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_pop;

    assign empty    = (count_reg == '0);
    assign room2    = (count_reg <= CW'(RES_DEPTH - 2));
    assign token    = q[rp_reg];
    assign do_pop   = pop && !empty;
    assign wp_plus1 = (wp_reg == AW'(RES_DEPTH - 1)) ? '0 : wp_reg + AW'(1);

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        if (wr0 && wr1)
        begin
            wp_next = (wp_plus1 == AW'(RES_DEPTH - 1)) ? '0 : wp_plus1 + AW'(1);
        end
        else if (wr0)
        begin
            wp_next = wp_plus1;
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == AW'(RES_DEPTH - 1)) ? '0 : rp_reg + AW'(1);
        end
        count_next = count_reg + CW'(wr0) + CW'(wr1) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            q[wp_reg] <= data0;
        end
        if (wr1)
        begin
            q[wp_plus1] <= data1;
        end
    end

endmodule

// ----- sv/tsd_engine.sv -----
// Back end: the recognizer state machine that grows tokens and builds results.
`timescale 1ns / 1ps

module tsd_engine
    import tsd_pkg::*;
#(
    parameter int KEY_CHARS   = KEY_CHARS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      avail,
    input  scan_cmd_t head,
    output logic      take,
    input  logic      room2,
    output logic      wr0,
    output token_t    res0,
    output logic      wr1,
    output token_t    res1
);

    localparam int IDXW = $clog2(KEY_CHARS);
    localparam int LW   = (LENGTH_BITS > TOKEN_LEN_W) ? LENGTH_BITS : TOKEN_LEN_W;

    typedef enum logic [1:0] {
        S_START,
        S_EXCL,
        S_TOKEN,
        S_COMMENT
    } scan_state_t;

    scan_state_t             state_reg, state_next;
    tok_kind_t               kind_reg, kind_next;
    logic [LENGTH_BITS-1:0]  len_reg, len_next;
    logic [30:0]             acc_reg, acc_next;
    logic                    ovf_reg, ovf_next;
    logic [31:0]             offset_reg, offset_next;
    logic [31:0]             start_reg, start_next;
    logic                    latched_reg, latched_next;

    logic [7:0]              kbuf [KEY_CHARS];
    logic                    buf_we;
    logic [IDXW-1:0]         buf_idx;

    logic                    kw_hit, kw_match;
    tok_kind_t               kw_kind;
    logic [LW-1:0]           len_wide;
    logic [15:0]             len_out;
    logic                    fin_err;
    token_t                  fin_res;
    logic                    ext, to_comment;
    tok_kind_t               ext_kind;
    logic [3:0]              digit;
    logic [34:0]             acc_x10;
    logic                    have_a, have_b, a_err, restart;
    token_t                  res_a, res_b;

    assign take  = avail && room2;
    assign digit = head.char_byte[3:0];
    assign acc_x10 = 35'({acc_reg, 3'b000}) + 35'({acc_reg, 1'b0}) + 35'(digit);

    // Keyword lookup over the kept prefix of an identifier.
    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = TK_ID;
        kw_match = 1'b0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            kw_match = (len_reg == LENGTH_BITS'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if ((j < KW_LEN[k]) &&
                    (kbuf[IDXW'(j)] != KW_TEXT[k][8*(KW_MAX_LEN-1-j) +: 8]))
                begin
                    kw_match = 1'b0;
                end
            end
            if (kw_match)
            begin
                kw_hit  = 1'b1;
                kw_kind = tok_kind_t'(6'(int'(TK_WAIN) + k));
            end
        end
    end

    assign len_wide = LW'(len_reg);
    assign len_out  = (len_wide > LW'(16'hFFFF)) ? 16'hFFFF : len_wide[15:0];
    assign fin_err  = (kind_reg == TK_NUM) && ovf_reg;

    // The result that closes the pending token.
    always_comb
    begin
        fin_res              = '0;
        fin_res.token_start  = start_reg;
        fin_res.token_length = len_out;
        if (fin_err)
        begin
            fin_res.error_code = ERR_NUM_RANGE;
        end
        else if (kind_reg == TK_NUM)
        begin
            fin_res.token_kind   = TK_NUM;
            fin_res.number_value = acc_reg;
        end
        else if (kind_reg == TK_ID && kw_hit)
        begin
            fin_res.token_kind = kw_kind;
        end
        else
        begin
            fin_res.token_kind = kind_reg;
        end
    end

    // Can the byte extend the pending token?
    always_comb
    begin
        ext        = 1'b0;
        to_comment = 1'b0;
        ext_kind   = kind_reg;
        if (state_reg == S_TOKEN)
        begin
            case (kind_reg)
                TK_ID:  ext = (head.cls inside {CC_ALPHA, CC_DIGIT});
                TK_NUM: ext = (head.cls == CC_DIGIT);
                TK_BECOMES:
                begin
                    ext      = (head.cls == CC_EQ);
                    ext_kind = TK_EQ;
                end
                TK_LT:
                begin
                    ext      = (head.cls == CC_EQ);
                    ext_kind = TK_LE;
                end
                TK_GT:
                begin
                    ext      = (head.cls == CC_EQ);
                    ext_kind = TK_GE;
                end
                TK_SLASH: to_comment = (head.cls == CC_SLASH);
                default: ext = 1'b0;
            endcase
        end
        else if (state_reg == S_EXCL)
        begin
            ext      = (head.cls == CC_EQ);
            ext_kind = TK_NE;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        offset_next  = offset_reg;
        start_next   = start_reg;
        latched_next = latched_reg;
        buf_we       = 1'b0;
        buf_idx      = '0;
        have_a       = 1'b0;
        have_b       = 1'b0;
        a_err        = 1'b0;
        restart      = 1'b0;
        res_a        = fin_res;
        res_b        = '0;
        res_b.error_code  = ERR_BAD_CHAR;
        res_b.token_start = offset_reg;

        if (take && !latched_reg)
        begin
            if (head.action)
            begin
                // End of input: flush whatever is pending.
                if (state_reg == S_EXCL)
                begin
                    have_a           = 1'b1;
                    res_a            = '0;
                    res_a.error_code = ERR_UNFINISHED;
                    res_a.token_start  = start_reg;
                    res_a.token_length = len_out;
                    latched_next     = 1'b1;
                end
                else if (state_reg == S_TOKEN)
                begin
                    have_a       = 1'b1;
                    latched_next = fin_err;
                end
                state_next = S_START;
            end
            else
            begin
                offset_next = offset_reg + 32'd1;
                if (state_reg == S_COMMENT)
                begin
                    if (head.cls == CC_NEWLINE)
                    begin
                        state_next = S_START;
                    end
                end
                else
                begin
                    restart = 1'b1;
                    if (state_reg != S_START)
                    begin
                        if (to_comment)
                        begin
                            state_next = S_COMMENT;
                            len_next   = '0;
                            restart    = 1'b0;
                        end
                        else if (ext)
                        begin
                            restart    = 1'b0;
                            state_next = S_TOKEN;
                            kind_next  = ext_kind;
                            if (len_reg < LENGTH_BITS'(KEY_CHARS))
                            begin
                                buf_we  = 1'b1;
                                buf_idx = len_reg[IDXW-1:0];
                            end
                            if (len_reg != '1)
                            begin
                                len_next = len_reg + LENGTH_BITS'(1);
                            end
                            if (ext_kind == TK_NUM && !ovf_reg)
                            begin
                                if (acc_x10 > 35'(NUM_MAX))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = acc_x10[30:0];
                                end
                            end
                        end
                        else
                        begin
                            // The byte closes the token and, unless that result is an error, is scanned again.
                            have_a = 1'b1;
                            if (state_reg == S_EXCL)
                            begin
                                res_a             = '0;
                                res_a.error_code  = ERR_BAD_CHAR;
                                res_a.token_start = offset_reg;
                                a_err             = 1'b1;
                            end
                            else
                            begin
                                a_err = fin_err;
                            end
                            latched_next = a_err;
                            state_next   = S_START;
                            len_next     = '0;
                        end
                    end
                    if (restart && !a_err && !(head.cls inside {CC_BLANK, CC_NEWLINE}))
                    begin
                        if (head.cls == CC_BAD)
                        begin
                            have_b       = 1'b1;
                            latched_next = 1'b1;
                        end
                        else
                        begin
                            state_next = (head.cls == CC_EXCL) ? S_EXCL : S_TOKEN;
                            kind_next  = head.start_kind;
                            start_next = offset_reg;
                            len_next   = LENGTH_BITS'(1);
                            buf_we     = 1'b1;
                            buf_idx    = '0;
                            ovf_next   = 1'b0;
                            acc_next   = (head.cls == CC_DIGIT) ? 31'(digit) : '0;
                        end
                    end
                end
            end
        end

        // Pack the results in order, marking the last one of this item.
        wr0  = have_a || have_b;
        wr1  = have_a && have_b;
        res0 = have_a ? res_a : res_b;
        res1 = res_b;
        res0.last_of_run = !wr1;
        res1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_START;
            kind_reg    <= TK_ID;
            len_reg     <= '0;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            offset_reg  <= '0;
            start_reg   <= '0;
            latched_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            len_reg     <= len_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            offset_reg  <= offset_next;
            start_reg   <= start_next;
            latched_reg <= latched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            kbuf[buf_idx] <= head.char_byte;
        end
    end

`ifndef SYNTH
    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |-> !wr0)
        else $error("result produced after an error was latched");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        wr1 |-> wr0 && take)
        else $error("second result without a first");

    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr0 |-> room2)
        else $error("result written without two free slots");

    a_error_latches: assert property (@(posedge clk) disable iff (!rst_n)
        ((wr0 && res0.error_code != ERR_NONE) || (wr1 && res1.error_code != ERR_NONE))
        |=> latched_reg)
        else $error("error result did not latch the error");

    a_offset_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |=> latched_reg && $stable(offset_reg))
        else $error("stream offset moved after an error");
`endif

endmodule

// ----- bench/token_checker.sv -----
// Checker that predicts the scanner's tokens from input transfers and compares result transfers.
`timescale 1ns / 1ps

module token_checker
    import tsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  scan_in_t cmd,
    input  logic     full,
    input  logic     empty,
    input  logic     pop,
    input  token_t   token,
    output int       mismatches,
    output int       waiting
);

    localparam logic [7:0]  CH_TAB  = 8'h09;
    localparam logic [7:0]  CH_NL   = 8'h0A;
    localparam logic [7:0]  CH_SP   = 8'h20;
    localparam logic [15:0] LEN_SAT = 16'hFFFF;

    typedef enum logic [1:0] {PH_IDLE, PH_BANG, PH_LEXEME, PH_COMMENT} scan_phase_t;

    scan_phase_t phase;
    tok_kind_t   lex_kind;
    logic [7:0]  lex_head [8];
    logic [15:0] lex_len;
    logic [30:0] num_acc;
    logic        num_over;
    logic [31:0] offset;
    logic [31:0] tok_start;
    logic        dead;
    token_t      pending_tokens [$];
    token_t      run_tokens [$];

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Kind of the token that a byte opens from the idle state; 0 if it opens none.
    function automatic logic opening_kind(input logic [7:0] c, output tok_kind_t kind);
        kind = TK_ID;
        if (is_letter(c))
            return 1'b1;
        if (is_digit(c))
        begin
            kind = TK_NUM;
            return 1'b1;
        end
        case (c)
            "(": kind = TK_LPAREN;
            ")": kind = TK_RPAREN;
            "{": kind = TK_LBRACE;
            "}": kind = TK_RBRACE;
            "=": kind = TK_BECOMES;
            "<": kind = TK_LT;
            ">": kind = TK_GT;
            "+": kind = TK_PLUS;
            "-": kind = TK_MINUS;
            "*": kind = TK_STAR;
            "/": kind = TK_SLASH;
            "%": kind = TK_PCT;
            ",": kind = TK_COMMA;
            ";": kind = TK_SEMI;
            "[": kind = TK_LBRACK;
            "]": kind = TK_RBRACK;
            "&": kind = TK_AMP;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Only the first bytes are kept, so words longer than seven can never be keywords.
    function automatic tok_kind_t word_kind();
        logic [55:0] text;
        text = '0;
        if (lex_len > 16'd7)
            return TK_ID;
        for (int i = 0; i < lex_len; i++)
            text[55 - 8*i -: 8] = lex_head[i];
        case (text)
            {"wain", 24'h0}:   return TK_WAIN;
            {"int", 32'h0}:    return TK_INT;
            {"if", 40'h0}:     return TK_IF;
            {"else", 24'h0}:   return TK_ELSE;
            {"while", 16'h0}:  return TK_WHILE;
            "println":         return TK_PRINTLN;
            {"return", 8'h0}:  return TK_RETURN;
            {"NULL", 24'h0}:   return TK_NULL;
            {"new", 32'h0}:    return TK_NEW;
            {"delete", 8'h0}:  return TK_DELETE;
            default:           return TK_ID;
        endcase
    endfunction

    task automatic emit(input tok_kind_t kind, input err_code_t err, input logic [31:0] st,
                        input logic [15:0] len, input logic [30:0] value);
        token_t t;
        t = '{kind, err, st, len, value, 1'b0};
        run_tokens.push_back(t);
    endtask

    task automatic close_lexeme();
        if (lex_kind == TK_NUM && num_over)
        begin
            emit(TK_ID, ERR_NUM_RANGE, tok_start, lex_len, '0);
            dead = 1'b1;
        end
        else if (lex_kind == TK_NUM)
            emit(TK_NUM, ERR_NONE, tok_start, lex_len, num_acc);
        else if (lex_kind == TK_ID)
            emit(word_kind(), ERR_NONE, tok_start, lex_len, '0);
        else
            emit(lex_kind, ERR_NONE, tok_start, lex_len, '0);
    endtask

    task automatic grow(input tok_kind_t kind, input logic [7:0] c);
        longint scaled;
        if (lex_len < 16'd8)
            lex_head[lex_len[2:0]] = c;
        if (lex_len != LEN_SAT)
            lex_len++;
        if (kind == TK_NUM && !num_over)
        begin
            scaled = longint'(num_acc) * 10 + longint'(c - "0");
            if (scaled > longint'(NUM_MAX))
                num_over = 1'b1;
            else
                num_acc = scaled[30:0];
        end
        lex_kind = kind;
        phase = PH_LEXEME;
    endtask

    task automatic open_lexeme(input logic [7:0] c, input logic [31:0] pos);
        tok_kind_t kind;
        phase = PH_LEXEME;
        tok_start = pos;
        lex_len = 16'd1;
        lex_head[0] = c;
        num_over = 1'b0;
        num_acc = '0;
        if (c == "!")
            phase = PH_BANG;
        else if (!opening_kind(c, kind))
        begin
            emit(TK_ID, ERR_BAD_CHAR, pos, '0, '0);
            dead = 1'b1;
            phase = PH_IDLE;
        end
        else
        begin
            lex_kind = kind;
            if (kind == TK_NUM)
                num_acc = 31'(c - "0");
        end
    endtask

    // Works out the tokens that one accepted input item causes.
    task automatic lex_step(input scan_in_t item);
        logic [7:0]  c;
        logic [31:0] pos;
        logic        handled;
        token_t      closing;
        run_tokens.delete();
        c = item.char_byte;
        pos = offset;
        if (dead)
            return;
        if (item.action)
        begin
            if (phase == PH_BANG)
            begin
                emit(TK_ID, ERR_UNFINISHED, tok_start, lex_len, '0);
                dead = 1'b1;
            end
            else if (phase == PH_LEXEME)
                close_lexeme();
            phase = PH_IDLE;
        end
        else
        begin
            offset = pos + 32'd1;
            if (phase == PH_COMMENT)
            begin
                if (c == CH_NL)
                    phase = PH_IDLE;
            end
            else
            begin
                handled = 1'b0;
                if (phase == PH_BANG && c == "=")
                begin
                    grow(TK_NE, c);
                    handled = 1'b1;
                end
                else if (phase == PH_LEXEME)
                begin
                    handled = 1'b1;
                    if (lex_kind == TK_ID && (is_letter(c) || is_digit(c)))
                        grow(TK_ID, c);
                    else if (lex_kind == TK_NUM && is_digit(c))
                        grow(TK_NUM, c);
                    else if (lex_kind == TK_BECOMES && c == "=")
                        grow(TK_EQ, c);
                    else if (lex_kind == TK_LT && c == "=")
                        grow(TK_LE, c);
                    else if (lex_kind == TK_GT && c == "=")
                        grow(TK_GE, c);
                    else if (lex_kind == TK_SLASH && c == "/")
                    begin
                        phase = PH_COMMENT;
                        lex_len = '0;
                    end
                    else
                        handled = 1'b0;
                end
                if (!handled && phase != PH_IDLE)
                begin
                    if (phase == PH_BANG)
                    begin
                        emit(TK_ID, ERR_BAD_CHAR, pos, '0, '0);
                        dead = 1'b1;
                    end
                    else
                        close_lexeme();
                    phase = PH_IDLE;
                    lex_len = '0;
                end
                if (!handled && !dead && c != CH_SP && c != CH_TAB && c != CH_NL)
                    open_lexeme(c, pos);
            end
        end
        if (run_tokens.size() > 0)
        begin
            closing = run_tokens.pop_back();
            closing.last_of_run = 1'b1;
            run_tokens.push_back(closing);
            foreach (run_tokens[i])
                pending_tokens.push_back(run_tokens[i]);
        end
    endtask

    task automatic report(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    task automatic check_token(input token_t got);
        token_t want;
        if (pending_tokens.size() == 0)
        begin
            $display("%0t: unexpected token, expected none, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = pending_tokens.pop_front();
        if (got.token_kind !== want.token_kind)
            report("token_kind", want.token_kind, got.token_kind);
        if (got.error_code !== want.error_code)
            report("error_code", want.error_code, got.error_code);
        if (got.token_start !== want.token_start)
            report("token_start", want.token_start, got.token_start);
        if (got.token_length !== want.token_length)
            report("token_length", want.token_length, got.token_length);
        if (got.number_value !== want.number_value)
            report("number_value", want.number_value, got.number_value);
        if (got.last_of_run !== want.last_of_run)
            report("last_of_run", want.last_of_run, got.last_of_run);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_IDLE;
            lex_kind = TK_ID;
            lex_len = '0;
            num_acc = '0;
            num_over = 1'b0;
            offset = '0;
            tok_start = '0;
            dead = 1'b0;
            pending_tokens.delete();
        end
        else
        begin
            if (push && !full)
                lex_step(cmd);
            if (pop && !empty)
                check_token(token);
        end
        waiting = pending_tokens.size();
    end

endmodule

// ----- bench/token_scanner_dfa_test.sv -----
// Testbench top for the token scanner: clock, reset, byte-stream stimulus and the verdict.
`timescale 1ns / 1ps

module token_scanner_dfa_test;
    import tsd_pkg::*;

    // Size of the random part, in bytes offered to the scanner.
    localparam int RANDOM_BYTES = 1900;
    // Length of the single long receiver hold-off.
    localparam int HOLD_CYCLES  = 300;
    // Bound on the run length; the watchdog reports a failure when it is reached.
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    scan_in_t cmd;
    token_t   token;

    int   mismatches;
    int   waiting;
    int   sent_count;
    int   cycles;
    logic tx_calm;
    logic rx_calm;
    logic hold_go;
    logic last_was_num;

    // Keywords and a few near misses that must stay plain identifiers.
    string word_list [15] = '{"wain", "int", "if", "else", "while", "println", "return",
                              "NULL", "new", "delete", "printlnx", "Wain", "null", "whil",
                              "deletes"};
    // Every punctuation kind, the two-byte ones spelled out whole.
    string punct_list [21] = '{"(", ")", "{", "}", "=", "==", "!=", "<", ">", "<=", ">=",
                               "+", "-", "*", "/", "%", ",", ";", "[", "]", "&"};

    token_scanner_dfa u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .cmd   (cmd),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .token (token)
    );

    // The checker sees both channels exactly as the block does and counts failures.
    token_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd        (cmd),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .token      (token),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle gaps: mostly none or short, now and then a long one. A calm side never idles.
    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 52) ? rand_letter() : 8'("0" + r - 52);
    endfunction

    // Offers one item at the falling edge and holds it until a rising edge sees
    // push high with full low. A back-to-back item keeps push high throughout.
    task automatic send_item(input logic act, input logic [7:0] ch);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            @(negedge clk) push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        cmd <= '{action: act, char_byte: ch};
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(1'b0, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // The character field is ignored on an end-of-input transfer, so it carries
    // random bytes, high bit included.
    task automatic send_flush();
        send_item(1'b1, 8'($urandom));
    endtask

    // Stops offering and waits until every predicted token has been transferred out.
    task automatic wait_drained();
        @(negedge clk) push <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
    endtask

    task automatic send_blanks();
        int n;
        int r;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(0, 2);
            send_char(r == 0 ? " " : (r == 1 ? CH_TAB : CH_NL));
        end
        last_was_num = 1'b0;
    endtask

    task automatic send_word();
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        send_char(rand_letter());
        repeat (n - 1)
            send_char(rand_alnum());
    endtask

    // Values stay within range; the largest legal value and leading zeros show up too.
    task automatic send_number();
        int          r;
        int unsigned v;
        r = $urandom_range(0, 19);
        if (r < 8)
            v = $urandom_range(0, 9);
        else if (r < 14)
            v = $urandom_range(0, 99999);
        else if (r < 18)
            v = $urandom_range(0, 2147483647);
        else if (r == 18)
            v = 2147483647;
        else
        begin
            send_text("000");
            v = $urandom_range(0, 999);
        end
        send_text($sformatf("%0d", v));
    endtask

    // Comment bodies take any byte but newline, which ends them.
    task automatic send_comment();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 12);
        send_text("//");
        repeat (n)
        begin
            do
                b = 8'($urandom);
            while (b == CH_NL);
            send_char(b);
        end
        send_char(CH_NL);
    endtask

    // One well-formed lexical unit. Two numbers in a row get a blank between
    // them, since merged digits could overflow and end the run early; a lone
    // bang is never sent, so nothing here can raise an error.
    task automatic send_random_unit();
        int   pick;
        logic after_num;
        pick = $urandom_range(0, 99);
        after_num = last_was_num;
        last_was_num = 1'b0;
        if (pick < 22)
            send_word();
        else if (pick < 32)
            send_text(word_list[$urandom_range(0, 14)]);
        else if (pick < 50)
        begin
            if (after_num)
                send_char(" ");
            send_number();
            last_was_num = 1'b1;
        end
        else if (pick < 74)
            send_text(punct_list[$urandom_range(0, 20)]);
        else if (pick < 80)
            send_comment();
        else if (pick < 84)
            send_flush();
        else
            send_blanks();
    endtask

    // Errors latch until reset, and reset comes only once, so a single error of
    // a randomly chosen sort closes the stream. Everything after it must be
    // swallowed without a result.
    task automatic provoke_error();
        logic [7:0] b;
        send_char(CH_NL);
        case ($urandom_range(0, 3))
            0:
            begin
                // A bad byte, sometimes right after a word so two results come at once.
                if ($urandom_range(0, 1))
                    send_word();
                case ($urandom_range(0, 3))
                    0:       b = CH_CR;
                    1:       b = 8'h80 | 8'($urandom_range(0, 127));
                    2:       b = "#";
                    default: b = 8'($urandom_range(0, 8));
                endcase
                send_char(b);
            end
            1:
            begin
                // One past the largest legal value, maybe with more digits behind it.
                send_text("2147483648");
                repeat ($urandom_range(0, 3))
                    send_char(8'("0" + $urandom_range(0, 9)));
                send_char(";");
            end
            2:
            begin
                // A bang left hanging at end of input.
                send_char("!");
                send_flush();
            end
            default:
            begin
                // A bang followed by anything but an equals sign.
                send_char("!");
                do
                    b = 8'($urandom);
                while (b == "=");
                send_char(b);
            end
        endcase
        repeat (30)
            send_item(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // Receiver: pops with random stalls, sometimes for long stretches without
    // any. Once the random part is under way it holds off once for a long stretch
    // so the result queue fills and full pushes back on the sender.
    initial
    begin : receiver
        int   stall_left;
        logic held;
        pop = 1'b0;
        rx_calm = 1'b0;
        stall_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 199) == 0)
                rx_calm = ~rx_calm;
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall_left = pick_gap(rx_calm);
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int   base;
        logic paused;
        rst_n = 1'b0;
        push = 1'b0;
        cmd = '0;
        tx_calm = 1'b0;
        hold_go = 1'b0;
        last_was_num = 1'b0;
        sent_count = 0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed opening: a keyword, an identifier, the two-byte compare, a
        // number with a leading zero, end of input right after punctuation, a
        // comment holding a high byte, and the largest number ended by end of input.
        send_text("if(x>=09)");
        send_flush();
        send_text("//");
        send_char(8'hFF);
        send_char(CH_NL);
        send_text("2147483647");
        send_flush();

        // The sender waits here until every token so far has been transferred.
        wait_drained();

        // Random well-formed stream, with calm stretches now and then.
        base = sent_count;
        while (sent_count - base < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 49) == 0)
                tx_calm = ~tx_calm;
            if (!hold_go && sent_count - base > RANDOM_BYTES / 3)
                hold_go = 1'b1;
            if (!paused && sent_count - base > 2 * RANDOM_BYTES / 3)
            begin
                paused = 1'b1;
                wait_drained();
            end
            send_random_unit();
        end
        tx_calm = 1'b0;

        provoke_error();

        // Drain, then give the pipeline time to show any stray result.
        wait_drained();
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tsd_pkg.sv
sv/tsd_front.sv
sv/tsd_result_fifo.sv
sv/tsd_engine.sv
sv/token_scanner_dfa.sv
bench/token_checker.sv
bench/token_scanner_dfa_test.sv
